// ===== rtl/core/sobel_pkg.sv =====
`timescale 1ns / 1ps

package sobel_pkg;

  // line store depth and derived column index width
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);

  localparam int unsigned PixW      = 8;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightW   = 16;
  localparam int unsigned RowW      = HeightW + 1;
  localparam int unsigned MagW      = 11;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 24;
  localparam int unsigned OutPadW   = TdataOutW - MagW - PixW;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoIdxW  = $clog2(FifoDepth);
  localparam int unsigned CntW      = FifoIdxW + 1;

  // window columns that survive from one item to the next
  localparam int unsigned NumCells  = 2;

  localparam logic [WidthRegW-1:0] WidthReset  = WidthRegW'(640);
  localparam logic [HeightW-1:0]   HeightReset = HeightW'(480);
  localparam logic [MagW-1:0]      ThreshReset = MagW'(150);

  localparam logic [PixW-1:0] EdgeOn  = PixW'(255);
  localparam logic [PixW-1:0] EdgeOff = PixW'(0);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } col_t;

  // per-column partials: top minus bottom, and top + 2*mid + bottom
  typedef struct packed {
    logic signed [PixW:0] diff;
    logic [PixW+1:0]      sum;
  } part_t;

  typedef struct packed {
    logic [PixW-1:0] lower;
    logic [PixW-1:0] upper;
  } lm_entry_t;

  typedef struct packed {
    logic            rd_en;
    logic [ColW-1:0] rd_addr;
    logic            wr_en;
    logic [ColW-1:0] wr_addr;
    lm_entry_t       wr_data;
  } lm_req_t;

  typedef struct packed {
    logic            last;
    logic [MagW-1:0] magnitude;
    logic [PixW-1:0] edge_res;
  } res_t;

  function automatic part_t col_part(col_t c);
    part_t p;
    p.diff = $signed({1'b0, c.top}) - $signed({1'b0, c.bot});
    p.sum  = {2'b00, c.top} + {1'b0, c.mid, 1'b0} + {2'b00, c.bot};
    return p;
  endfunction

endpackage

// ===== rtl/core/sobel_edge_threshold_top.sv =====
`timescale 1ns / 1ps

// 3x3 Sobel edge detector with threshold. Grey pixels enter in raster order at up to one
// item per clock; each pixel gives |gx|+|gy| and 255 or 0 against edge_threshold, with
// pixels outside the image taken as zero. Results lag the input by one row plus one pixel,
// so after the last pixel of a frame width+1 flush items (or further pixel items, whose
// values are dropped) drain the rest; a flush before the frame is complete is taken and
// ignored. The last result of a frame carries tlast and the next frame starts at once. A
// result passes stages b, c, d and the output queue. Rows are kept in one 1024-entry line
// store read and written once per item, and a window of two column cells shifts once per
// item. Results sit in an 8-entry output queue; s_axis_tready stays high while fewer than
// eight results are owed, which at a free output gives one item per cycle. No clearing
// pass is needed after reset. The user must write cfg port registers only while no item
// is in flight; the block does not enforce it. Writing width or height restarts the frame.
module sobel_edge_threshold_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sobel_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [sobel_pkg::CfgDataW-1:0]     cfg_data_i,
  // pixel stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sobel_pkg::TdataInW-1:0]     s_axis_tdata,  // [7:0] pixel
  input  logic [0:0]                         s_axis_tuser,  // [0] cmd
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sobel_pkg::TdataOutW-1:0]    m_axis_tdata,  // [7:0] edge_res, [18:8] magnitude
  output logic                               m_axis_tlast   // last_of_frame
);

  localparam int unsigned ColW = sobel_pkg::ColW;
  localparam int unsigned RowW = sobel_pkg::RowW;
  localparam int unsigned PixW = sobel_pkg::PixW;
  localparam int unsigned MagW = sobel_pkg::MagW;
  localparam int unsigned CntW = sobel_pkg::CntW;

  // configuration registers
  logic [sobel_pkg::WidthRegW-1:0] width_q;
  logic [sobel_pkg::HeightW-1:0]   height_q;
  logic [MagW-1:0]                 thresh_q;
  logic                            cfg_restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_restart = cfg_valid_i && ((cfg_addr_i == sobel_pkg::CFG_WIDTH) ||
                                       (cfg_addr_i == sobel_pkg::CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sobel_pkg::WidthReset;
      height_q <= sobel_pkg::HeightReset;
      thresh_q <= sobel_pkg::ThreshReset;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        sobel_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[sobel_pkg::WidthRegW-1:0];
        sobel_pkg::CFG_HEIGHT: height_q <= cfg_data_i[sobel_pkg::HeightW-1:0];
        sobel_pkg::CFG_THRESH: thresh_q <= cfg_data_i[MagW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [sobel_pkg::WidthRegW-1:0] w_eff;
  logic [sobel_pkg::HeightW-1:0]   h_eff;
  logic [RowW-1:0]                 h_ext, h_p1;

  assign w_eff = (width_q == '0) ? sobel_pkg::WidthRegW'(1) :
                 (width_q > sobel_pkg::WidthRegW'(sobel_pkg::MaxWidth)) ?
                 sobel_pkg::WidthRegW'(sobel_pkg::MaxWidth) : width_q;
  assign h_eff = (height_q == '0) ? sobel_pkg::HeightW'(1) : height_q;
  assign h_ext = {1'b0, h_eff};
  assign h_p1  = h_ext + RowW'(1);

  // input position counters
  logic [ColW-1:0]                 ic_q, ic_d, ic_eff;
  logic [RowW-1:0]                 ir_q, ir_d;
  logic [sobel_pkg::WidthRegW-1:0] ic_inc;
  logic                            in_frame, col0, ignore, take, acc;
  logic                            emit_a, last_a, wrap;
  logic [PixW-1:0]                 v_a;

  assign ic_eff   = ({1'b0, ic_q} >= w_eff) ? '0 : ic_q;
  assign ic_inc   = {1'b0, ic_eff} + sobel_pkg::WidthRegW'(1);
  assign wrap     = (ic_inc >= w_eff);
  assign in_frame = (ir_q < h_ext);
  assign col0     = (ic_eff == '0);
  assign ignore   = in_frame && (s_axis_tuser == sobel_pkg::CMD_FLUSH);
  assign v_a      = in_frame ? s_axis_tdata[PixW-1:0] : '0;
  // column zero closes the row two above; other columns finish the row one above
  assign emit_a   = col0 ? ((ir_q >= RowW'(2)) && (ir_q <= h_p1)) :
                           ((ir_q != '0) && (ir_q <= h_ext));
  assign last_a   = col0 && (ir_q == h_p1);

  assign acc  = s_axis_tvalid && s_axis_tready;
  assign take = acc && !ignore;

  always_comb begin
    ic_d = ic_q;
    ir_d = ir_q;
    if (cfg_restart) begin
      ic_d = '0;
      ir_d = '0;
    end else if (take) begin
      if (last_a) begin
        ic_d = '0;
        ir_d = '0;
      end else if (wrap) begin
        ic_d = '0;
        ir_d = ir_q + RowW'(1);
      end else begin
        ic_d = ic_inc[ColW-1:0];
      end
    end
  end

  // results owed to the output queue
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign cnt_d         = cnt_q + CntW'(take && emit_a) - CntW'(pop);
  assign s_axis_tready = (cnt_q < CntW'(sobel_pkg::FifoDepth));

  // stage b: line store data back, window shift
  logic            b_valid_q, b_emit_q, b_last_q;
  logic            b_col0_q, b_g1_q, b_g2_q;
  logic [ColW-1:0] b_ic_q;
  logic [PixW-1:0] b_v_q;

  // stage c: shifted window as column partials
  logic             c_valid_q, c_last_q;
  sobel_pkg::part_t c_part_q [3];

  // stage d: gradients
  logic                   d_valid_q, d_last_q;
  logic signed [MagW-1:0] gx_q, gy_q, gx_d, gy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q      <= '0;
      ir_q      <= '0;
      cnt_q     <= '0;
      b_valid_q <= 1'b0;
      b_emit_q  <= 1'b0;
      b_last_q  <= 1'b0;
      c_valid_q <= 1'b0;
      c_last_q  <= 1'b0;
      d_valid_q <= 1'b0;
      d_last_q  <= 1'b0;
    end else begin
      ic_q      <= ic_d;
      ir_q      <= ir_d;
      cnt_q     <= cnt_d;
      b_valid_q <= take;
      b_emit_q  <= take && emit_a;
      b_last_q  <= take && last_a;
      c_valid_q <= b_valid_q && b_emit_q;
      c_last_q  <= b_last_q;
      d_valid_q <= c_valid_q;
      d_last_q  <= c_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      b_col0_q <= col0;
      b_g1_q   <= (ir_q != '0);
      b_g2_q   <= (ir_q >= RowW'(2));
      b_ic_q   <= ic_eff;
      b_v_q    <= v_a;
    end
  end

  // line store: upper takes the old lower, lower takes the new pixel
  sobel_pkg::lm_req_t   lm_req;
  sobel_pkg::lm_entry_t lm_rd;

  always_comb begin
    lm_req               = '0;
    lm_req.rd_en         = take;
    lm_req.rd_addr       = ic_eff;
    lm_req.wr_en         = b_valid_q;
    lm_req.wr_addr       = b_ic_q;
    lm_req.wr_data.lower = b_v_q;
    lm_req.wr_data.upper = lm_rd.lower;
  end

  sobel_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (lm_req),
    .rd_data_o (lm_rd)
  );

  // rows above the image read as zero
  sobel_pkg::col_t  new_col;
  sobel_pkg::part_t chain [sobel_pkg::NumCells + 1];

  always_comb begin
    new_col.top = b_g2_q ? lm_rd.upper : '0;
    new_col.mid = b_g1_q ? lm_rd.lower : '0;
    new_col.bot = b_v_q;
  end

  assign chain[sobel_pkg::NumCells] = sobel_pkg::col_part(new_col);

  for (genvar k = 0; k < sobel_pkg::NumCells; k++) begin : g_cell
    sobel_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (b_valid_q),
      .zap_i  ((k == sobel_pkg::NumCells - 1) ? 1'b0 : b_col0_q),
      .part_i (chain[k+1]),
      .part_o (chain[k])
    );
  end

  // at column zero the right-hand column of the closing row lies outside
  always_ff @(posedge clk_i) begin
    if (b_valid_q && b_emit_q) begin
      c_part_q[0] <= chain[0];
      c_part_q[1] <= chain[1];
      c_part_q[2] <= b_col0_q ? '0 : chain[sobel_pkg::NumCells];
    end
  end

  assign gx_d = MagW'($signed(c_part_q[0].diff)) + (MagW'($signed(c_part_q[1].diff)) <<< 1)
              + MagW'($signed(c_part_q[2].diff));
  assign gy_d = $signed({1'b0, c_part_q[0].sum}) - $signed({1'b0, c_part_q[2].sum});

  always_ff @(posedge clk_i) begin
    if (c_valid_q) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  // magnitude and threshold
  logic [MagW-1:0] gx_abs, gy_abs, mag;
  sobel_pkg::res_t res_d, res_q;

  assign gx_abs = gx_q[MagW-1] ? MagW'(-gx_q) : gx_q;
  assign gy_abs = gy_q[MagW-1] ? MagW'(-gy_q) : gy_q;
  assign mag    = gx_abs + gy_abs;

  always_comb begin
    res_d.last      = d_last_q;
    res_d.magnitude = mag;
    res_d.edge_res  = (mag >= thresh_q) ? sobel_pkg::EdgeOn : sobel_pkg::EdgeOff;
  end

  sobel_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (d_valid_q),
    .data_i  (res_d),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_q)
  );

  assign m_axis_tdata = {{sobel_pkg::OutPadW{1'b0}}, res_q.magnitude, res_q.edge_res};
  assign m_axis_tlast = res_q.last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(sobel_pkg::FifoDepth))
    else $error("owed result count exceeds the output queue");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_a) |=> (ic_q == '0 && ir_q == '0))
    else $error("frame did not restart after its last item");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ir_q <= h_p1)
    else $error("input row ran past the drain row");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_last_q) |-> b_emit_q)
    else $error("last of frame flagged on an item without a result");

endmodule

// ===== rtl/core/sobel_line_mem.sv =====
`timescale 1ns / 1ps

module sobel_line_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sobel_pkg::lm_req_t   req_i,
  output sobel_pkg::lm_entry_t rd_data_o
);

  sobel_pkg::lm_entry_t mem_q [sobel_pkg::MaxWidth];
  sobel_pkg::lm_entry_t rd_q;
  sobel_pkg::lm_entry_t byp_q;
  logic                 byp_sel_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q  <= mem_q[req_i.rd_addr];
      byp_q <= req_i.wr_data;
    end
  end

  // read and write of the same column in one cycle: hand over the new entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_sel_q <= 1'b0;
    end else if (req_i.rd_en) begin
      byp_sel_q <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr);
    end
  end

  assign rd_data_o = byp_sel_q ? byp_q : rd_q;

endmodule

// ===== rtl/core/sobel_cell.sv =====
`timescale 1ns / 1ps

module sobel_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             zap_i,
  input  sobel_pkg::part_t part_i,
  output sobel_pkg::part_t part_o
);

  sobel_pkg::part_t part_d;
  sobel_pkg::part_t part_q;

  // a new row starts with empty columns to the left
  assign part_d = zap_i ? '0 : part_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
    end else if (en_i) begin
      part_q <= part_d;
    end
  end

  assign part_o = part_q;

endmodule

// ===== rtl/core/sobel_out_fifo.sv =====
`timescale 1ns / 1ps

module sobel_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sobel_pkg::res_t   data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sobel_pkg::res_t   data_o
);

  sobel_pkg::res_t                  mem_q [sobel_pkg::FifoDepth];
  logic [sobel_pkg::FifoIdxW:0]     wr_ptr_q, wr_ptr_d;
  logic [sobel_pkg::FifoIdxW:0]     rd_ptr_q, rd_ptr_d;

  assign valid_o = (wr_ptr_q != rd_ptr_q);
  assign data_o  = mem_q[rd_ptr_q[sobel_pkg::FifoIdxW-1:0]];

  assign wr_ptr_d = wr_ptr_q + (sobel_pkg::FifoIdxW + 1)'(push_i);
  assign rd_ptr_d = rd_ptr_q + (sobel_pkg::FifoIdxW + 1)'(valid_o && ready_i);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[sobel_pkg::FifoIdxW-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sobel_pkg::*;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            reg_idx;
    logic [CfgDataW-1:0] wdata;
    cmd_e                cmd;
    logic [PixW-1:0]     pix;
    bit                  typed;
    res_t                want;
  } dir_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_addr_i    = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TdataInW-1:0]  s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // shadow of the block: line stores, window, raster position, registers
  logic [PixW-1:0]      store_upper [MaxWidth];
  logic [PixW-1:0]      store_lower [MaxWidth];
  logic [PixW-1:0]      win [9];
  int unsigned          col_in;
  int unsigned          row_in;
  logic [WidthRegW-1:0] reg_width  = WidthReset;
  logic [HeightW-1:0]   reg_height = HeightReset;
  logic [MagW-1:0]      reg_thresh = ThreshReset;

  res_t                 owed_results [$];
  int unsigned          n_bad         = 0;
  int unsigned          src_idle_pct  = 0;
  int unsigned          snk_stall_pct = 0;
  bit                   exp_fixed_vld = 1'b0;
  res_t                 exp_fixed     = '0;

  sobel_edge_threshold_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic void frame_restart();
    win    = '{default: '0};
    col_in = 0;
    row_in = 0;
  endfunction

  function automatic bit sobel_predict(input cmd_e cmd, input logic [PixW-1:0] pix,
                                       output res_t res);
    int unsigned     w, h, ic, ir, cr, cc;
    logic [PixW-1:0] v, up, lo;
    int              p [9];
    int              g_row, g_col, mag;
    bit              hit;
    w = (reg_width == 0) ? 1 : (reg_width > MaxWidth) ? MaxWidth : reg_width;
    h = (reg_height == 0) ? 1 : reg_height;
    res = '0;
    // once every pixel of the frame is in, any item drains and its value is dropped
    if (row_in < h) begin
      if (cmd == CMD_FLUSH) return 1'b0;
      v = pix;
    end else begin
      v = '0;
    end
    ic = (col_in >= w) ? 0 : col_in;
    ir = row_in;
    up = (ir >= 2) ? store_upper[ic] : '0;
    lo = (ir >= 1) ? store_lower[ic] : '0;
    store_upper[ic] = store_lower[ic];
    store_lower[ic] = v;
    for (int k = 0; k < 9; k += 3) begin
      win[k]   = win[k+1];
      win[k+1] = win[k+2];
    end
    // first column of a row closes the previous row with zeros on its right
    win[2] = (ic == 0) ? '0 : up;
    win[5] = (ic == 0) ? '0 : lo;
    win[8] = (ic == 0) ? '0 : v;
    foreach (p[k]) p[k] = int'(win[k]);
    g_row = p[0] + 2 * p[1] + p[2] - p[6] - 2 * p[7] - p[8];
    g_col = p[0] + 2 * p[3] + p[6] - p[2] - 2 * p[5] - p[8];
    mag = (g_row < 0 ? -g_row : g_row) + (g_col < 0 ? -g_col : g_col);
    if (ic == 0) begin
      hit = (ir >= 2) && (ir - 2 < h);
      cr  = ir - 2;
      cc  = w - 1;
      win = '{default: '0};
      win[2] = up;
      win[5] = lo;
      win[8] = v;
    end else begin
      hit = (ir >= 1) && (ir - 1 < h);
      cr  = ir - 1;
      cc  = ic - 1;
    end
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir++;
    end
    col_in = ic;
    row_in = ir;
    if (hit) begin
      res.edge_res  = (mag >= int'(reg_thresh)) ? EdgeOn : EdgeOff;
      res.magnitude = MagW'(mag);
      res.last      = (cr == h - 1) && (cc == w - 1);
      if (res.last) frame_restart();
    end
    return hit;
  endfunction

  // accepted items feed the shadow model, accepted results are checked in order
  always @(posedge clk_i) begin
    res_t r, got, want;
    bit   hit;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        hit = sobel_predict(cmd_e'(s_axis_tuser), s_axis_tdata, r);
        if (exp_fixed_vld) owed_results.push_back(exp_fixed);
        else if (hit) owed_results.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.edge_res  = m_axis_tdata[PixW-1:0];
        got.magnitude = m_axis_tdata[PixW +: MagW];
        got.last      = m_axis_tlast;
        if (owed_results.size() == 0) begin
          if (n_bad < 10) begin
            $display("unexpected result: edge %0d magnitude %0d last %0b",
                     got.edge_res, got.magnitude, got.last);
          end
          n_bad++;
        end else begin
          want = owed_results.pop_front();
          if (got.edge_res !== want.edge_res || got.magnitude !== want.magnitude ||
              got.last !== want.last) begin
            if (n_bad < 10) begin
              $display("mismatch: edge %0d/%0d magnitude %0d/%0d last %0b/%0b (exp/act)",
                       want.edge_res, got.edge_res, want.magnitude, got.magnitude,
                       want.last, got.last);
            end
            n_bad++;
          end
        end
      end
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [PixW-1:0] pix);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WIDTH: begin
        reg_width = d[WidthRegW-1:0];
        frame_restart();
      end
      CFG_HEIGHT: begin
        reg_height = d;
        frame_restart();
      end
      CFG_THRESH: reg_thresh = d[MagW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (owed_results.size() != 0);
  endtask

  // items that give no result may still be inside the pipeline
  task automatic settle();
    hold_until_drained();
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    dir_row_t             dir_tab [$];
    int unsigned          frame_no, n_rand, ew, eh, n_pix, cut, style, base, spin;
    logic [WidthRegW-1:0] w_set;
    logic [HeightW-1:0]   h_set;
    logic [MagW-1:0]      t_set;
    logic [PixW-1:0]      px;
    bit                   clean, big, broken, t_first;

    foreach (store_upper[i]) begin
      store_upper[i] = '0;
      store_lower[i] = '0;
    end
    frame_restart();

    // 1x1 frame with width and height of zero: lone pixel has zero weight
    dir_tab.push_back(dir_row_t'{1'b1, CFG_THRESH, '0, CMD_PIXEL, '0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b1, CFG_WIDTH, '0, CMD_PIXEL, '0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b1, CFG_HEIGHT, '0, CMD_PIXEL, '0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'hFF, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'h00, 1'b0, '0});
    // pixel after the frame drains; zero threshold makes it an edge
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'hA5, 1'b1,
                                 res_t'{1'b1, MagW'(0), EdgeOn}});
    // flush at the start of the next frame is dropped
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'h5A, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b1, CFG_THRESH, 16'hFFFF, CMD_PIXEL, '0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'h00, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'hFF, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'h00, 1'b1,
                                 res_t'{1'b1, MagW'(0), EdgeOff}});
    // 3x2 checkerboard, junk above the width bits, flush in mid-frame
    dir_tab.push_back(dir_row_t'{1'b1, CFG_WIDTH, 16'hF803, CMD_PIXEL, '0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b1, CFG_HEIGHT, 16'd2, CMD_PIXEL, '0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b1, CFG_THRESH, 16'd400, CMD_PIXEL, '0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'hFF, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'h00, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'hFF, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'hFF, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'h00, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'hFF, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'h00, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'h00, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_PIXEL, 8'hFF, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'h00, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{1'b0, CFG_WIDTH, '0, CMD_FLUSH, 8'h00, 1'b0, '0});

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg) settle();
        cfg_write(dir_tab[i].reg_idx, dir_tab[i].wdata);
      end else begin
        exp_fixed_vld = dir_tab[i].typed;
        exp_fixed     = dir_tab[i].want;
        send_item(dir_tab[i].cmd, dir_tab[i].pix);
      end
    end
    exp_fixed_vld = 1'b0;

    frame_no = 0;
    n_rand   = 0;
    clean    = 1'b0;
    while (n_rand < 650) begin
      case ((frame_no / 2) % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 59; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 59; end
        default: begin src_idle_pct = 37; snk_stall_pct = 37; end
      endcase
      // one full-width frame, one frame that is far too tall to finish
      big = (frame_no == 3);
      case ($urandom_range(9))
        0: t_set = '0;
        1: t_set = MagW'(2040);
        2: t_set = MagW'($urandom_range(2047, 2041));
        3: t_set = MagW'($urandom_range(2040, 601));
        default: t_set = MagW'($urandom_range(600));
      endcase
      if (big || frame_no == 5 || !clean || $urandom_range(1) == 0) begin
        case ($urandom_range(9))
          0: w_set = '0;
          1: w_set = WidthRegW'($urandom_range(40, 13));
          default: w_set = WidthRegW'($urandom_range(12, 1));
        endcase
        h_set = ($urandom_range(9) == 0) ? '0 : HeightW'($urandom_range(6, 1));
        if (big) begin
          w_set = '1;
          h_set = HeightW'(1);
        end
        if (frame_no == 5) h_set = '1;
        t_first = $urandom_range(1);
        settle();
        if (t_first) cfg_write(CFG_THRESH, {(CfgDataW-MagW)'($urandom), t_set});
        cfg_write(CFG_WIDTH, {(CfgDataW-WidthRegW)'($urandom), w_set});
        cfg_write(CFG_HEIGHT, h_set);
        if (!t_first) cfg_write(CFG_THRESH, {(CfgDataW-MagW)'($urandom), t_set});
        ew = (w_set == 0) ? 1 : (w_set > MaxWidth) ? MaxWidth : w_set;
        eh = (h_set == 0) ? 1 : h_set;
      end else if ($urandom_range(1) == 0) begin
        settle();
        cfg_write(CFG_THRESH, {(CfgDataW-MagW)'($urandom), t_set});
      end
      n_pix  = ew * eh;
      broken = (frame_no == 5) || (!big && $urandom_range(7) == 0);
      cut    = broken ? $urandom_range((n_pix < 4 * ew + 4) ? n_pix : 4 * ew + 4, 1) : n_pix;
      style  = $urandom_range(2);
      base   = $urandom_range(255);
      for (int k = 0; k < cut; k++) begin
        if (!big && $urandom_range(24) == 0) send_item(CMD_FLUSH, PixW'($urandom));
        case (style)
          0: px = PixW'($urandom);
          1: px = $urandom_range(1) ? 8'hFF : 8'h00;
          default: px = PixW'(base + $urandom_range(24));
        endcase
        send_item(CMD_PIXEL, px);
        if (!big && $urandom_range(59) == 0) hold_until_drained();
      end
      if (!broken) begin
        // drain the last row plus one, by flush ticks or surplus pixels
        for (int k = 0; k <= ew; k++) begin
          send_item($urandom_range(1) ? CMD_FLUSH : CMD_PIXEL, PixW'($urandom));
        end
        if ($urandom_range(3) == 0) send_item(CMD_FLUSH, PixW'($urandom));
      end
      if (!big) n_rand += cut + (broken ? 0 : ew + 1);
      clean = !broken;
      frame_no++;
    end

    s_axis_tvalid <= 1'b0;
    spin = 0;
    do begin
      @(negedge clk_i);
      spin++;
    end while (owed_results.size() != 0 && spin < 20000);
    repeat (16) @(negedge clk_i);
    if (owed_results.size() != 0) begin
      $display("%0d results never arrived", owed_results.size());
      n_bad++;
    end
    if (n_bad == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
